// ===== src/bp_pkg.sv =====
// Shared types and constants for the MSB-first bit packer.
package bp_pkg;

  // Fixed field widths
  localparam int OP_W          = 2;
  localparam int CODE_VALUE_W  = 32;
  localparam int BIT_COUNT_W   = 6;
  localparam int BYTE_BITS     = 8;
  localparam int PEND_W        = BYTE_BITS - 1;
  localparam int PCNT_W        = 3;
  localparam int BYTE_CNT_W    = 32;

  // Default code width limit
  localparam int DEF_MAX_CODE_BITS = 32;

  // Register port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_BYTE_LIMIT = 1'b0;
  localparam logic [CFG_DATA_W-1:0] BYTE_LIMIT_RESET = '1;

  // Item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_FINISH = 2'd1,
    OP_START  = 2'd2
  } op_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } bp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic step_done;
  } bp_status_t;

endpackage

// ===== src/bp_in_if.sv =====
// Input item channel: valid/ready handshake with code payload.
interface bp_in_if
  import bp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [CODE_VALUE_W-1:0] code_value;
  logic [BIT_COUNT_W-1:0]  bit_count;

  modport source (output valid, output op, output code_value, output bit_count,
                  input ready);
  modport sink   (input valid, input op, input code_value, input bit_count,
                  output ready);
endinterface

// ===== src/bp_out_if.sv =====
// Result item channel: valid/ready handshake with one packed byte.
interface bp_out_if
  import bp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] out_byte;
  logic                 last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== src/bp_regs.sv =====
// APB-style register block holding the byte limit.
module bp_regs
  import bp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [BYTE_CNT_W-1:0] byte_limit
);

  logic [CFG_DATA_W-1:0] byte_limit_r;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r <= BYTE_LIMIT_RESET;
    end else if (wr_en && (reg_idx == REG_BYTE_LIMIT)) begin
      byte_limit_r <= pwdata;
    end
  end

  // read decode
  always_comb begin
    unique case (reg_idx)
      REG_BYTE_LIMIT: prdata = byte_limit_r;
      default:        prdata = '0;
    endcase
  end

  assign byte_limit = byte_limit_r[BYTE_CNT_W-1:0];

endmodule

// ===== src/bp_ctrl.sv =====
// Controller: takes an item, then runs packing steps until it is done.
module bp_ctrl
  import bp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  bp_status_t status,
  output bp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_BUSY;
      end
      ST_BUSY: begin
        if (status.out_free && status.step_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_BUSY: begin
        cmd.step = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/bp_dpath.sv =====
// Datapath: pending bits, left-aligned code, byte counter and output register.
module bp_dpath
  import bp_pkg::*;
#(
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bp_cmd_t                 cmd,
  output bp_status_t              status,
  input  logic [OP_W-1:0]         in_op,
  input  logic [CODE_VALUE_W-1:0] in_code_value,
  input  logic [BIT_COUNT_W-1:0]  in_bit_count,
  input  logic [BYTE_CNT_W-1:0]   byte_limit,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [BYTE_BITS-1:0]    out_byte,
  output logic                    out_last
);

  localparam logic [BIT_COUNT_W-1:0] MAX_N = BIT_COUNT_W'(MAX_CODE_BITS);

  // item registers
  op_t                      op_r;
  logic [MAX_CODE_BITS-1:0] code_r, code_nxt;
  logic [BIT_COUNT_W-1:0]   n_r, n_nxt;

  // stream state
  logic [PEND_W-1:0]        pend_r, pend_nxt;
  logic [PCNT_W-1:0]        pcnt_r, pcnt_nxt;
  logic [BYTE_CNT_W-1:0]    bytes_r, bytes_nxt;
  logic                     active_r, active_nxt;

  // output register
  logic                     out_valid_r;
  logic [BYTE_BITS-1:0]     out_byte_r;
  logic                     out_last_r;

  // step signals
  logic [BIT_COUNT_W-1:0]   n_load;
  logic [MAX_CODE_BITS-1:0] code_load;
  logic [BYTE_BITS-1:0]     top8, top_sel;
  logic [PEND_W+BYTE_BITS-1:0] sel_sh, app_sh;
  logic [3:0]               missing, app_amt;
  logic [BIT_COUNT_W-1:0]   rest, total;
  logic [BYTE_CNT_W-1:0]    bytes_inc;
  logic                     limit_hit, next_hit;
  logic                     emit_c, emit_last, closing, step_done;

  // clamp count and left-align the code so the first bit sits at the top
  assign n_load    = (in_bit_count > MAX_N) ? MAX_N : in_bit_count;
  assign code_load = in_code_value[MAX_CODE_BITS-1:0] << (MAX_N - n_load);

  // byte assembly from pending bits and the top of the code
  assign top8    = code_r[MAX_CODE_BITS-1 -: BYTE_BITS];
  assign top_sel = closing ? '0 : top8;
  assign sel_sh  = {pend_r, top_sel} >> pcnt_r;
  assign app_amt = 4'(BYTE_BITS) - {1'b0, n_r[2:0]};
  assign app_sh  = {pend_r, top8} >> app_amt;
  assign missing = 4'(BYTE_BITS) - {1'b0, pcnt_r};
  assign rest    = n_r - {2'b00, missing};
  assign total   = n_r + {3'b000, pcnt_r};

  // saturating byte count and limit checks
  assign bytes_inc = (bytes_r == '1) ? bytes_r : bytes_r + 1'b1;
  assign limit_hit = (bytes_r >= byte_limit);
  assign next_hit  = (bytes_inc >= byte_limit);

  // one packing step
  always_comb begin
    pend_nxt   = pend_r;
    pcnt_nxt   = pcnt_r;
    n_nxt      = n_r;
    code_nxt   = code_r;
    bytes_nxt  = bytes_r;
    active_nxt = active_r;
    emit_c     = 1'b0;
    emit_last  = 1'b0;
    closing    = 1'b0;
    step_done  = 1'b1;
    case (op_r)
      OP_WRITE: begin
        if (!active_r || (n_r == '0)) begin
          step_done = 1'b1;
        end else if (limit_hit) begin
          // limit reached: flush partial byte and close
          closing    = 1'b1;
          emit_c     = (pcnt_r != '0);
          emit_last  = 1'b1;
          pend_nxt   = '0;
          pcnt_nxt   = '0;
          active_nxt = 1'b0;
          bytes_nxt  = emit_c ? bytes_inc : bytes_r;
        end else if (total < BIT_COUNT_W'(BYTE_BITS)) begin
          // code fits in the pending buffer
          pend_nxt = app_sh[PEND_W-1:0];
          pcnt_nxt = total[PCNT_W-1:0];
          n_nxt    = '0;
        end else begin
          // a full byte is ready
          emit_c    = 1'b1;
          emit_last = !((rest >= BIT_COUNT_W'(BYTE_BITS)) && !next_hit);
          code_nxt  = code_r << missing;
          n_nxt     = rest;
          pend_nxt  = '0;
          pcnt_nxt  = '0;
          bytes_nxt = bytes_inc;
          step_done = (rest == '0);
        end
      end
      OP_FINISH: begin
        closing    = 1'b1;
        emit_c     = active_r && (pcnt_r != '0);
        emit_last  = 1'b1;
        pend_nxt   = '0;
        pcnt_nxt   = '0;
        active_nxt = 1'b0;
        bytes_nxt  = emit_c ? bytes_inc : bytes_r;
      end
      OP_START: begin
        closing    = 1'b1;
        emit_c     = active_r && (pcnt_r != '0);
        emit_last  = 1'b1;
        pend_nxt   = '0;
        pcnt_nxt   = '0;
        active_nxt = 1'b1;
        bytes_nxt  = '0;
      end
      default: begin
        step_done = 1'b1;
      end
    endcase
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      code_r <= code_load;
      n_r    <= n_load;
    end else if (cmd.step) begin
      code_r <= code_nxt;
      n_r    <= n_nxt;
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      pcnt_r   <= '0;
      bytes_r  <= '0;
      active_r <= 1'b1;
    end else if (cmd.step) begin
      pend_r   <= pend_nxt;
      pcnt_r   <= pcnt_nxt;
      bytes_r  <= bytes_nxt;
      active_r <= active_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step && emit_c) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit_c) begin
      out_byte_r <= sel_sh[BYTE_BITS-1:0];
      out_last_r <= emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last         = out_last_r;
  assign status.out_free  = !out_valid_r || out_ready;
  assign status.step_done = step_done;

  // pending bits always fit in the pending count
  a_pend_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r >> pcnt_r) == '0)
    else $error("pending bits exceed pending count");

  // a byte is only produced when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && emit_c) |-> status.out_free)
    else $error("byte produced while output register is full");

  // a closed stream ignores write items
  a_closed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && (op_r == OP_WRITE) && !active_r) |-> (!emit_c && step_done))
    else $error("write on closed stream produced output");

  // remaining code bits never exceed the code width
  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (n_r <= MAX_N))
    else $error("remaining bit count out of range");

endmodule

// ===== src/bit_packer_msb_first.sv =====
// MSB-first variable-length bit packer: one code per input item, one byte per
// result item. An item is taken while the packer is idle, then it runs one step
// per cycle: each step emits at most one byte, appends a short tail to the
// pending buffer, or closes the stream. Steps pause while the output register
// holds an untaken byte, and a new item is not taken until the last one is done.
// byte_limit (address 0) closes the stream once that many bytes have gone out.
module bit_packer_msb_first
  import bp_pkg::*;
#(
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bp_in_if.sink                 in_if,
  bp_out_if.source              out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  bp_cmd_t               cmd;
  bp_status_t            status;
  logic [BYTE_CNT_W-1:0] byte_limit;
  logic                  in_ready;

  // configuration registers
  bp_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .byte_limit (byte_limit)
  );

  // sequencing
  bp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_if.ready = in_ready;

  // packing datapath
  bp_dpath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_op         (in_if.op),
    .in_code_value (in_if.code_value),
    .in_bit_count  (in_if.bit_count),
    .byte_limit    (byte_limit),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_byte      (out_if.out_byte),
    .out_last      (out_if.last)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the MSB-first bit packer.
`timescale 1ns / 1ps

module tb
  import bp_pkg::*;
();

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_BITS     = DEF_MAX_CODE_BITS;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = CFG_ADDR_W'(4 * REG_BYTE_LIMIT);

  // Packer predictor plus the queue of bytes still owed by the block
  class packer_scoreboard;
    typedef struct packed {
      logic [BYTE_BITS-1:0] data;
      logic                 last;
    } packed_byte_t;

    packed_byte_t         byte_q[$];
    logic [31:0]          byte_limit;
    logic [PEND_W-1:0]    pend_bits;
    logic [PCNT_W-1:0]    pend_cnt;
    logic [31:0]          emitted;
    bit                   active;
    int                   errors;
    int                   bytes_checked;
    int                   limit_closes;

    function new();
      byte_limit    = BYTE_LIMIT_RESET;
      pend_bits     = '0;
      pend_cnt      = '0;
      emitted       = '0;
      active        = 1'b1;
      errors        = 0;
      bytes_checked = 0;
      limit_closes  = 0;
    endfunction

    function int pending();
      return byte_q.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void emit_byte(logic [BYTE_BITS-1:0] data);
      packed_byte_t b;
      b.data = data;
      b.last = 1'b0;
      byte_q.push_back(b);
      if (emitted != 32'hFFFF_FFFF) emitted++;
      pend_bits = '0;
      pend_cnt  = '0;
    endfunction

    // Pad the partial byte with zeros and shut the stream
    function void close_stream();
      int unsigned acc;
      if (active && pend_cnt != 0) begin
        acc = pend_bits;
        acc = (acc << (BYTE_BITS - pend_cnt)) & 32'hFF;
        emit_byte(acc[7:0]);
      end
      active = 1'b0;
    endfunction

    // Append a code MSB first, checking the limit before every chunk
    function void pack_code(logic [31:0] value, logic [BIT_COUNT_W-1:0] nbits);
      int unsigned n, v, missing, rest, acc;
      n = (nbits > MAX_BITS) ? MAX_BITS : nbits;
      v = (n >= 32) ? value : value & ((32'd1 << n) - 1);
      while (active && n > 0) begin
        if (emitted >= byte_limit) begin
          limit_closes++;
          close_stream();
          return;
        end
        if (pend_cnt + n < BYTE_BITS) begin
          acc = pend_bits;
          acc = ((acc << n) | v) & 32'h7F;
          pend_bits = acc[6:0];
          pend_cnt  = PCNT_W'(pend_cnt + n);
          n = 0;
        end else begin
          missing = BYTE_BITS - pend_cnt;
          rest    = n - missing;
          acc = pend_bits;
          acc = ((acc << missing) | (v >> rest)) & 32'hFF;
          emit_byte(acc[7:0]);
          n = rest;
          v = v & ((32'd1 << n) - 1);
        end
      end
    endfunction

    // Work out the bytes for one accepted item; returns 1 if it did anything
    function bit note_item(logic [OP_W-1:0] op, logic [31:0] value,
                           logic [BIT_COUNT_W-1:0] nbits);
      int  before_sz;
      bit  effect;
      before_sz = byte_q.size();
      effect    = 1'b0;
      if (op == OP_WRITE) begin
        effect = active && nbits != 0;
        pack_code(value, nbits);
      end else if (op == OP_FINISH) begin
        effect = active;
        close_stream();
      end else if (op == OP_START) begin
        effect = 1'b1;
        close_stream();
        pend_bits = '0;
        pend_cnt  = '0;
        emitted   = '0;
        active    = 1'b1;
      end
      if (byte_q.size() > before_sz) byte_q[byte_q.size()-1].last = 1'b1;
      return effect;
    endfunction

    function void check_byte(logic [BYTE_BITS-1:0] data, logic last);
      packed_byte_t want;
      bytes_checked++;
      if (byte_q.size() == 0) begin
        flag($sformatf("unexpected byte %02h last %0b", data, last));
        return;
      end
      want = byte_q.pop_front();
      if (data !== want.data || last !== want.last)
        flag($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                       bytes_checked, want.data, want.last, data, last));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  bp_in_if  in_ch ();
  bp_out_if out_ch ();

  bit quiet;
  int useful;
  int op_seen [4];
  int limit_settings;
  packer_scoreboard sb;

  bit_packer_msb_first dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Byte receiver: random stall bursts, one long hold-off, none when quiet
  initial begin
    int burst, hold, reroll;
    bit stall_on, pressured;
    burst = 0;
    hold = 0;
    reroll = 0;
    stall_on = 1'b1;
    pressured = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!pressured && sb.bytes_checked >= 40) begin
        hold = HOLD_CYCLES;
        pressured = 1'b1;
      end
      if (reroll == 0) begin
        stall_on = $urandom_range(0, 3) != 0;
        reroll = 64;
      end
      reroll--;
      if (hold > 0) begin
        hold--;
        out_ch.ready = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ch.ready = 1'b0;
      end else if (!quiet && stall_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 15);
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_byte(out_ch.out_byte, out_ch.last);
    end
  end

  // Offer one item and hold it until the packer takes it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [31:0] value,
                           input logic [BIT_COUNT_W-1:0] nbits);
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.op         = op;
    in_ch.code_value = value;
    in_ch.bit_count  = nbits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (sb.note_item(op, value, nbits)) useful++;
    op_seen[op]++;
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic cfg_read_check(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] want);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      sb.flag($sformatf("byte_limit read %08h, expected %08h", prdata, want));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Change the limit only once every owed byte is out and the packer is idle
  task automatic set_limit(input logic [31:0] value);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(LIMIT_ADDR, value);
    cfg_read_check(LIMIT_ADDR, value);
    sb.byte_limit = value;
    limit_settings++;
  endtask

  // Mostly writes of random codes, with finish, start and the unused op mixed in
  task automatic run_random(input int n_items);
    int gap, stretch, r;
    bit gaps_on;
    logic [OP_W-1:0] op;
    logic [BIT_COUNT_W-1:0] nbits;
    stretch = 0;
    gaps_on = 1'b0;
    repeat (n_items) begin
      if (stretch == 0) begin
        gaps_on = !quiet && $urandom_range(0, 3) != 0;
        stretch = 32;
      end
      stretch--;
      r = $urandom_range(0, 99);
      if (r < 72)      op = OP_WRITE;
      else if (r < 80) op = OP_FINISH;
      else if (r < 92) op = OP_START;
      else             op = OP_UNUSED;
      r = $urandom_range(0, 19);
      if (r == 0)      nbits = '0;
      else if (r == 1) nbits = BIT_COUNT_W'(MAX_BITS);
      else if (r == 2) nbits = BIT_COUNT_W'($urandom_range(MAX_BITS + 1, 63));
      else             nbits = BIT_COUNT_W'($urandom_range(1, MAX_BITS - 1));
      send_item(op, $urandom(), nbits);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 16);
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    quiet = 1'b0;
    useful = 0;
    limit_settings = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_WRITE;
    in_ch.code_value = '0;
    in_ch.bit_count = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    cfg_read_check(LIMIT_ADDR, BYTE_LIMIT_RESET);

    // Directed: field extremes, masking, clamping, closed stream, restarts
    send_item(OP_WRITE, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_WRITE, 32'hFFFF_FFFF, 6'd32);
    send_item(OP_WRITE, 32'h0000_0000, 6'd32);
    send_item(OP_WRITE, 32'h0000_0001, 6'd1);
    send_item(OP_WRITE, 32'h0000_007F, 6'd7);
    send_item(OP_WRITE, 32'hFFFF_FFF5, 6'd3);
    send_item(OP_FINISH, 32'h0, 6'd0);
    send_item(OP_FINISH, 32'h0, 6'd0);
    send_item(OP_WRITE, 32'h0000_00A5, 6'd8);
    send_item(OP_START, 32'hFFFF_FFFF, 6'd63);
    send_item(OP_WRITE, 32'h0000_0013, 6'd5);
    send_item(OP_START, 32'h0, 6'd0);
    send_item(OP_WRITE, 32'h1234_5678, 6'd63);
    send_item(OP_WRITE, 32'h8000_0001, 6'd33);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
    send_item(OP_WRITE, 32'h0000_0055, 6'd7);
    send_item(OP_WRITE, 32'hDEAD_BEEF, 6'd32);
    send_item(OP_FINISH, 32'h0, 6'd0);
    send_item(OP_START, 32'h0, 6'd0);

    // Zero limit: the first chunk of any write closes the stream
    set_limit(32'h0000_0000);
    send_item(OP_WRITE, 32'h0000_00AB, 6'd8);
    send_item(OP_WRITE, 32'h0000_00AB, 6'd8);
    send_item(OP_START, 32'h0, 6'd0);

    // Limit hit in the middle of a code with bits waiting
    set_limit(32'h0000_0002);
    send_item(OP_WRITE, 32'h0000_000A, 6'd4);
    send_item(OP_WRITE, 32'h0000_1234, 6'd16);
    send_item(OP_WRITE, 32'h0000_00FF, 6'd8);
    send_item(OP_START, 32'h0, 6'd0);

    // Random phases across several limits
    set_limit(32'hFFFF_FFFF);
    run_random(140);
    set_limit(32'h0000_0009);
    run_random(100);
    set_limit(32'h0000_0000);
    run_random(25);
    set_limit(32'hFFFF_FFFE);
    run_random(40);
    quiet = 1'b1;
    set_limit(32'h8000_0000);
    run_random(80);

    // Drain and report
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d items, %0d with an effect (write %0d, finish %0d, start %0d, unused op %0d),",
             op_seen[OP_WRITE] + op_seen[OP_FINISH] + op_seen[OP_START] + op_seen[OP_UNUSED],
             useful, op_seen[OP_WRITE], op_seen[OP_FINISH], op_seen[OP_START],
             op_seen[OP_UNUSED]);
    $display("%0d bytes checked, %0d limit closures, %0d byte_limit settings, %0d errors.",
             sb.bytes_checked, sb.limit_closes, limit_settings, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
